### hdl/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types, constants and rectangle helpers for the dirty-rectangle
// tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package drt_pkg;

  localparam int MAX_REGIONS = 8;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int COORD_W     = 15;
  localparam int RIDX_W      = 3;
  localparam int MERGE_W     = 16;

  localparam logic [1:0] CFG_SURF_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SURF_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SURF_READY  = 2'd2;

  typedef enum logic [1:0] {
    CMD_INV_ALL  = 2'd0,
    CMD_INV_RECT = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } box_t;

  typedef struct packed {
    logic usable;
    logic empty;
    box_t box;
  } clip_res_t;

  function automatic box_t box_union(box_t a, box_t b);
    logic [COORD_W:0]   ax2;
    logic [COORD_W:0]   bx2;
    logic [COORD_W:0]   ay2;
    logic [COORD_W:0]   by2;
    logic [COORD_W:0]   x2;
    logic [COORD_W:0]   y2;
    box_t               o;
    ax2 = {1'b0, a.x} + {1'b0, a.w};
    bx2 = {1'b0, b.x} + {1'b0, b.w};
    ay2 = {1'b0, a.y} + {1'b0, a.h};
    by2 = {1'b0, b.y} + {1'b0, b.h};
    x2  = (ax2 > bx2) ? ax2 : bx2;
    y2  = (ay2 > by2) ? ay2 : by2;
    o.x = (a.x < b.x) ? a.x : b.x;
    o.y = (a.y < b.y) ? a.y : b.y;
    o.w = COORD_W'(x2 - {1'b0, o.x});
    o.h = COORD_W'(y2 - {1'b0, o.y});
    return o;
  endfunction

  function automatic logic box_touches(box_t a, box_t b);
    logic nz;
    logic hx;
    logic hy;
    nz = (a.w != '0) && (a.h != '0) && (b.w != '0) && (b.h != '0);
    hx = ({1'b0, a.x} <= ({1'b0, b.x} + {1'b0, b.w})) &&
         (({1'b0, a.x} + {1'b0, a.w}) >= {1'b0, b.x});
    hy = ({1'b0, a.y} <= ({1'b0, b.y} + {1'b0, b.h})) &&
         (({1'b0, a.y} + {1'b0, a.h}) >= {1'b0, b.y});
    return nz && hx && hy;
  endfunction

endpackage

`default_nettype wire

### hdl/drt_region_ram.sv
// ----------------------------------------------------------------------------
// drt_region_ram
// Region list storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_region_ram
  import drt_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  box_t             wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output box_t             rdata
);

  box_t mem [MAX_REGIONS];
  box_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/drt_clip.sv
// ----------------------------------------------------------------------------
// drt_clip
// Clips a signed rectangle against the surface and checks surface usability.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_clip
  import drt_pkg::*;
(
  input  logic [COORD_W-1:0] surf_w,
  input  logic [COORD_W-1:0] surf_h,
  input  logic               surf_rdy,
  input  logic [15:0]        rect_x,
  input  logic [15:0]        rect_y,
  input  logic [15:0]        rect_w,
  input  logic [15:0]        rect_h,
  output clip_res_t          res
);

  typedef struct packed {
    logic               empty;
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] len;
  } axis_t;

  function automatic axis_t clip_axis(logic [15:0] s, logic [15:0] n,
                                      logic [COORD_W-1:0] lim);
    logic signed [17:0] s_e;
    logic signed [17:0] e_e;
    logic signed [17:0] l_e;
    logic signed [17:0] hi;
    logic signed [17:0] lo_e;
    axis_t              a;
    s_e     = $signed({{2{s[15]}}, s});
    e_e     = s_e + $signed({2'b00, n});
    l_e     = $signed({3'b000, lim});
    hi      = (e_e < l_e) ? e_e : l_e;
    a.lo    = s[15] ? '0 : s[COORD_W-1:0];
    lo_e    = $signed({3'b000, a.lo});
    a.empty = (n == '0) || (hi <= lo_e);
    a.len   = COORD_W'(hi[COORD_W-1:0] - a.lo);
    return a;
  endfunction

  axis_t ax;
  axis_t ay;

  always_comb begin
    ax         = clip_axis(rect_x, rect_w, surf_w);
    ay         = clip_axis(rect_y, rect_h, surf_h);
    res.usable = surf_rdy && (surf_w != '0) && (surf_h != '0);
    res.empty  = ax.empty || ay.empty;
    res.box.x  = ax.lo;
    res.box.y  = ay.lo;
    res.box.w  = ax.len;
    res.box.h  = ay.len;
  end

endmodule

`default_nettype wire

### hdl/dirty_rect_tracker_top.sv
// Sequence: invalidate-all, clear and query go from accept through the clip, read and
// output states; invalidate-rect scans the list, reading and then comparing each entry
// on the one RAM read port until one merges or the list ends, then reads and outputs.
// Flow: one item at a time; the next is taken the cycle after the result loads.
// Reset (rst_n, synchronous) clears control, counters, bounds and config;
// the region RAM is not cleared and its read data is used only below the stored count.
// ----------------------------------------------------------------------------
// dirty_rect_tracker_top
// Dirty-rectangle merge list: sequencer, bounds and counters around the
// region RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module dirty_rect_tracker_top
  import drt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_W-1:0]    cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic signed [15:0]    in_rect_x,
  input  logic signed [15:0]    in_rect_y,
  input  logic [15:0]           in_rect_w,
  input  logic [15:0]           in_rect_h,
  input  logic [RIDX_W-1:0]     in_read_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_dirty_flag,
  output logic [COORD_W-1:0]    out_bound_x,
  output logic [COORD_W-1:0]    out_bound_y,
  output logic [COORD_W-1:0]    out_bound_w,
  output logic [COORD_W-1:0]    out_bound_h,
  output logic [3:0]            out_rect_count,
  output logic [MERGE_W-1:0]    out_merge_count,
  output logic                  out_entry_valid,
  output logic [COORD_W-1:0]    out_entry_x,
  output logic [COORD_W-1:0]    out_entry_y,
  output logic [COORD_W-1:0]    out_entry_w,
  output logic [COORD_W-1:0]    out_entry_h
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLIP,
    S_SCAN,
    S_CMP,
    S_READ,
    S_OUT
  } state_t;

  state_t              state_r;
  cmd_t                cmd_r;
  logic [15:0]         rx_r;
  logic [15:0]         ry_r;
  logic [15:0]         rw_r;
  logic [15:0]         rh_r;
  logic [RIDX_W-1:0]   idx_r;
  logic [COORD_W-1:0]  surf_w_r;
  logic [COORD_W-1:0]  surf_h_r;
  logic                surf_rdy_r;
  box_t                bbox_r;
  logic                has_bounds_r;
  logic [CNT_W-1:0]    count_r;
  logic [MERGE_W-1:0]  merges_r;
  logic                redraw_r;
  box_t                clip_r;
  logic [CNT_W-1:0]    scan_r;

  logic                out_valid_r;
  logic                out_dirty_r;
  box_t                out_bound_r;
  logic [3:0]          out_count_r;
  logic [MERGE_W-1:0]  out_merges_r;
  logic                out_ev_r;
  box_t                out_entry_r;

  clip_res_t           clip;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  box_t                ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  box_t                ram_rdata;
  box_t                full_box;
  box_t                merged;
  logic                hit;
  logic                ev;
  logic                out_load;

  drt_clip u_clip (
    .surf_w   (surf_w_r),
    .surf_h   (surf_h_r),
    .surf_rdy (surf_rdy_r),
    .rect_x   (rx_r),
    .rect_y   (ry_r),
    .rect_w   (rw_r),
    .rect_h   (rh_r),
    .res      (clip)
  );

  drt_region_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign full_box = '{x: '0, y: '0, w: surf_w_r, h: surf_h_r};
  assign merged   = box_union(ram_rdata, clip_r);
  assign hit      = box_touches(ram_rdata, clip_r);
  assign ev       = has_bounds_r &&
                    ({{CNT_W{1'b0}}, idx_r} < {{RIDX_W{1'b0}}, count_r});
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_r[IDX_W-1:0];
    ram_wdata = clip_r;
    ram_re    = 1'b0;
    ram_raddr = IDX_W'(idx_r);
    case (state_r)
      S_CLIP: begin
        if (cmd_r == CMD_INV_ALL && clip.usable) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = full_box;
        end
      end
      S_SCAN: begin
        if (scan_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = scan_r[IDX_W-1:0];
        end else if (count_r < CNT_W'(MAX_REGIONS)) begin
          ram_we    = 1'b1;
          ram_waddr = count_r[IDX_W-1:0];
        end else begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = bbox_r;
        end
      end
      S_CMP: begin
        if (hit) begin
          ram_we    = 1'b1;
          ram_wdata = merged;
        end
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      surf_w_r     <= '0;
      surf_h_r     <= '0;
      surf_rdy_r   <= 1'b0;
      bbox_r       <= '0;
      has_bounds_r <= 1'b0;
      count_r      <= '0;
      merges_r     <= '0;
      redraw_r     <= 1'b0;
      scan_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SURF_WIDTH:  surf_w_r   <= cfg_wdata;
          CFG_SURF_HEIGHT: surf_h_r   <= cfg_wdata;
          CFG_SURF_READY:  surf_rdy_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end

      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= cmd_t'(in_command);
            rx_r    <= in_rect_x;
            ry_r    <= in_rect_y;
            rw_r    <= in_rect_w;
            rh_r    <= in_rect_h;
            idx_r   <= in_read_index;
            state_r <= S_CLIP;
          end
        end
        S_CLIP: begin
          state_r <= S_READ;
          case (cmd_r)
            CMD_INV_ALL: begin
              if (clip.usable) begin
                bbox_r       <= full_box;
                has_bounds_r <= 1'b1;
                count_r      <= CNT_W'(1);
                merges_r     <= '0;
              end
              redraw_r <= 1'b1;
            end
            CMD_INV_RECT: begin
              if (clip.usable && !clip.empty) begin
                bbox_r       <= has_bounds_r ? box_union(bbox_r, clip.box) : clip.box;
                has_bounds_r <= 1'b1;
                redraw_r     <= 1'b1;
                clip_r       <= clip.box;
                scan_r       <= '0;
                state_r      <= S_SCAN;
              end
            end
            CMD_CLEAR: begin
              bbox_r       <= '0;
              has_bounds_r <= 1'b0;
              count_r      <= '0;
              merges_r     <= '0;
              redraw_r     <= 1'b0;
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          if (scan_r < count_r) begin
            state_r <= S_CMP;
          end else begin
            if (count_r < CNT_W'(MAX_REGIONS)) begin
              count_r <= count_r + CNT_W'(1);
            end else begin
              count_r  <= CNT_W'(1);
              merges_r <= merges_r + MERGE_W'(1);
            end
            state_r <= S_READ;
          end
        end
        S_CMP: begin
          if (hit) begin
            merges_r <= merges_r + MERGE_W'(1);
            state_r  <= S_READ;
          end else begin
            scan_r  <= scan_r + CNT_W'(1);
            state_r <= S_SCAN;
          end
        end
        S_READ: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            out_dirty_r  <= redraw_r;
            out_bound_r  <= bbox_r;
            out_count_r  <= has_bounds_r ? 4'(count_r) : '0;
            out_merges_r <= has_bounds_r ? merges_r : '0;
            out_ev_r     <= ev;
            out_entry_r  <= ev ? ram_rdata : '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_dirty_flag  = out_dirty_r;
  assign out_bound_x     = out_bound_r.x;
  assign out_bound_y     = out_bound_r.y;
  assign out_bound_w     = out_bound_r.w;
  assign out_bound_h     = out_bound_r.h;
  assign out_rect_count  = out_count_r;
  assign out_merge_count = out_merges_r;
  assign out_entry_valid = out_ev_r;
  assign out_entry_x     = out_entry_r.x;
  assign out_entry_y     = out_entry_r.y;
  assign out_entry_w     = out_entry_r.w;
  assign out_entry_h     = out_entry_r.h;

endmodule

`default_nettype wire

### hdl/drt_checker.sv
// ----------------------------------------------------------------------------
// drt_checker
// Port-level checks on the tracker's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_checker
  import drt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COORD_W-1:0] out_bound_x,
  input logic [3:0]         out_rect_count,
  input logic [MERGE_W-1:0] out_merge_count,
  input logic               out_entry_valid,
  input logic [COORD_W-1:0] out_entry_x,
  input logic [COORD_W-1:0] out_entry_y,
  input logic [COORD_W-1:0] out_entry_w,
  input logic [COORD_W-1:0] out_entry_h
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bound_x) &&
      $stable(out_merge_count) && $stable(out_entry_x))
    else $error("result item changed while stalled");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rect_count <= 4'(MAX_REGIONS))
    else $error("rect_count above list depth");

  a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rect_count == '0 |-> !out_entry_valid && out_merge_count == '0)
    else $error("entry or merges reported with empty list");

  a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |->
      out_entry_x == '0 && out_entry_y == '0 && out_entry_w == '0 && out_entry_h == '0)
    else $error("invalid entry not zeroed");

endmodule

bind dirty_rect_tracker_top drt_checker u_drt_checker (.*);

`default_nettype wire

### tb/tb_dirty_rect_tracker_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dirty_rect_tracker_top
// Self-checking bench for the dirty-rectangle tracker. A short directed
// table covers reset, unusable surfaces, clipping extremes, merge, append and
// collapse; random phases follow across several surface settings under
// varying backpressure. Each result is checked against a fixed or a behavioral-tracker view.
// ----------------------------------------------------------------------------

module tb_dirty_rect_tracker_top;
  import drt_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 30;
  localparam int NUM_PHASES   = 9;

  typedef struct packed {
    logic                dirty;
    logic [COORD_W-1:0]  bx;
    logic [COORD_W-1:0]  by;
    logic [COORD_W-1:0]  bw;
    logic [COORD_W-1:0]  bh;
    logic [3:0]          cnt;
    logic [MERGE_W-1:0]  merges;
    logic                ev;
    logic [COORD_W-1:0]  ex;
    logic [COORD_W-1:0]  ey;
    logic [COORD_W-1:0]  ew;
    logic [COORD_W-1:0]  eh;
  } tracker_view_t;

  typedef struct {
    cmd_t               cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [2:0]         ridx;
  } damage_req_t;

  typedef struct {
    bit            is_cfg;
    int            cw;
    int            ch;
    bit            crdy;
    damage_req_t   req;
    bit            typed;
    tracker_view_t view;
  } plan_row_t;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } area_t;

  localparam tracker_view_t VIEW_RESET = '0;
  localparam tracker_view_t VIEW_DIRTY_ONLY =
    {1'b1, 15'd0, 15'd0, 15'd0, 15'd0, 4'd0, 16'd0, 1'b0, 15'd0, 15'd0, 15'd0, 15'd0};
  localparam tracker_view_t VIEW_FULL =
    {1'b1, 15'd0, 15'd0, 15'd32767, 15'd32767, 4'd1, 16'd0,
     1'b1, 15'd0, 15'd0, 15'd32767, 15'd32767};
  localparam tracker_view_t VIEW_FULL_BOUND =
    {1'b1, 15'd0, 15'd0, 15'd32767, 15'd32767, 4'd1, 16'd0,
     1'b0, 15'd0, 15'd0, 15'd0, 15'd0};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_SURF_WIDTH;
  logic [COORD_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = CMD_QUERY;
  logic signed [15:0] in_rect_x = '0;
  logic signed [15:0] in_rect_y = '0;
  logic [15:0]        in_rect_w = '0;
  logic [15:0]        in_rect_h = '0;
  logic [RIDX_W-1:0]  in_read_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_dirty_flag;
  logic [COORD_W-1:0] out_bound_x;
  logic [COORD_W-1:0] out_bound_y;
  logic [COORD_W-1:0] out_bound_w;
  logic [COORD_W-1:0] out_bound_h;
  logic [3:0]         out_rect_count;
  logic [MERGE_W-1:0] out_merge_count;
  logic               out_entry_valid;
  logic [COORD_W-1:0] out_entry_x;
  logic [COORD_W-1:0] out_entry_y;
  logic [COORD_W-1:0] out_entry_w;
  logic [COORD_W-1:0] out_entry_h;

  dirty_rect_tracker_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_rect_x       (in_rect_x),
    .in_rect_y       (in_rect_y),
    .in_rect_w       (in_rect_w),
    .in_rect_h       (in_rect_h),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dirty_flag  (out_dirty_flag),
    .out_bound_x     (out_bound_x),
    .out_bound_y     (out_bound_y),
    .out_bound_w     (out_bound_w),
    .out_bound_h     (out_bound_h),
    .out_rect_count  (out_rect_count),
    .out_merge_count (out_merge_count),
    .out_entry_valid (out_entry_valid),
    .out_entry_x     (out_entry_x),
    .out_entry_y     (out_entry_y),
    .out_entry_w     (out_entry_w),
    .out_entry_h     (out_entry_h)
  );

  always #5 clk = ~clk;

  // tracker state and surface settings
  area_t         reg_list [MAX_REGIONS];
  int            reg_cnt = 0;
  area_t         bbox = '{0, 0, 0, 0};
  bit            bbox_set = 1'b0;
  bit [15:0]     merge_ctr = '0;
  bit            redraw = 1'b0;
  int            surf_w = 0;
  int            surf_h = 0;
  bit            surf_rdy = 1'b0;

  tracker_view_t view_q [$];
  plan_row_t     plan [$];
  int            errors = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  bit            hold_go = 1'b0;
  logic          hold_on = 1'b0;

  function automatic area_t area_join(area_t a, area_t b);
    area_t o;
    int    xe;
    int    ye;
    xe  = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
    ye  = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
    o.x = (a.x < b.x) ? a.x : b.x;
    o.y = (a.y < b.y) ? a.y : b.y;
    o.w = xe - o.x;
    o.h = ye - o.y;
    return o;
  endfunction

  function automatic tracker_view_t track_cmd(damage_req_t r);
    tracker_view_t v;
    area_t         c;
    int            x1;
    int            y1;
    int            x2;
    int            y2;
    bit            usable;
    bit            hit;
    usable = surf_rdy && surf_w != 0 && surf_h != 0;
    case (r.cmd)
      CMD_INV_ALL: begin
        if (usable) begin
          bbox        = '{0, 0, surf_w, surf_h};
          bbox_set    = 1'b1;
          reg_list[0] = bbox;
          reg_cnt     = 1;
          merge_ctr   = '0;
        end
        redraw = 1'b1;
      end
      CMD_INV_RECT: begin
        if (usable && r.w != 0 && r.h != 0) begin
          x1 = (int'(r.x) > 0) ? int'(r.x) : 0;
          y1 = (int'(r.y) > 0) ? int'(r.y) : 0;
          x2 = int'(r.x) + int'(r.w);
          y2 = int'(r.y) + int'(r.h);
          if (x2 > surf_w) x2 = surf_w;
          if (y2 > surf_h) y2 = surf_h;
          if (x2 > x1 && y2 > y1) begin
            c        = '{x1, y1, x2 - x1, y2 - y1};
            bbox     = bbox_set ? area_join(bbox, c) : c;
            bbox_set = 1'b1;
            hit      = 1'b0;
            // first entry that overlaps or shares an edge absorbs the rect
            for (int i = 0; i < reg_cnt; i++) begin
              if (!hit && reg_list[i].x <= c.x + c.w && reg_list[i].x + reg_list[i].w >= c.x &&
                  reg_list[i].y <= c.y + c.h && reg_list[i].y + reg_list[i].h >= c.y) begin
                reg_list[i] = area_join(reg_list[i], c);
                merge_ctr++;
                hit = 1'b1;
              end
            end
            if (!hit) begin
              if (reg_cnt < MAX_REGIONS) begin
                reg_list[reg_cnt] = c;
                reg_cnt++;
              end else begin
                reg_list[0] = bbox;
                reg_cnt     = 1;
                merge_ctr++;
              end
            end
            redraw = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        bbox      = '{0, 0, 0, 0};
        reg_cnt   = 0;
        merge_ctr = '0;
        bbox_set  = 1'b0;
        redraw    = 1'b0;
      end
      default: ;
    endcase
    v       = '0;
    v.dirty = redraw;
    v.bx    = 15'(bbox.x);
    v.by    = 15'(bbox.y);
    v.bw    = 15'(bbox.w);
    v.bh    = 15'(bbox.h);
    if (bbox_set) begin
      v.cnt    = 4'(reg_cnt);
      v.merges = merge_ctr;
      if (int'(r.ridx) < reg_cnt) begin
        v.ev = 1'b1;
        v.ex = 15'(reg_list[r.ridx].x);
        v.ey = 15'(reg_list[r.ridx].y);
        v.ew = 15'(reg_list[r.ridx].w);
        v.eh = 15'(reg_list[r.ridx].h);
      end
    end
    return v;
  endfunction

  function automatic damage_req_t next_req();
    damage_req_t r;
    int          roll;
    int          sw;
    int          sh;
    int          gx;
    int          gy;
    sw     = (surf_w > 0) ? surf_w : 64;
    sh     = (surf_h > 0) ? surf_h : 64;
    r.ridx = 3'($urandom_range(7));
    r.x    = 16'($urandom);
    r.y    = 16'($urandom);
    r.w    = 16'($urandom);
    r.h    = 16'($urandom);
    roll   = $urandom_range(99);
    if (roll < 3) r.cmd = CMD_INV_ALL;
    else if (roll < 6) r.cmd = CMD_CLEAR;
    else if (roll < 18) r.cmd = CMD_QUERY;
    else begin
      r.cmd = CMD_INV_RECT;
      roll  = $urandom_range(99);
      if (roll < 35) begin
        // tiles on a grid so that neighbors share edges exactly
        gx  = (sw / 8 > 0) ? sw / 8 : 1;
        gy  = (sh / 8 > 0) ? sh / 8 : 1;
        r.x = 16'(gx * $urandom_range(7));
        r.y = 16'(gy * $urandom_range(7));
        r.w = 16'(gx);
        r.h = 16'(gy);
      end else if (roll < 85) begin
        r.x = 16'(int'($urandom_range(sw + 16)) - 16);
        r.y = 16'(int'($urandom_range(sh + 16)) - 16);
        r.w = 16'($urandom_range(sw / 4 + 1, 1));
        r.h = 16'($urandom_range(sh / 4 + 1, 1));
      end
    end
    return r;
  endfunction

  task automatic plan_cfg(int w, int h, bit rdy);
    plan_row_t p;
    p.is_cfg   = 1'b1;
    p.cw       = w;
    p.ch       = h;
    p.crdy     = rdy;
    p.req.cmd  = CMD_QUERY;
    p.req.x    = '0;
    p.req.y    = '0;
    p.req.w    = '0;
    p.req.h    = '0;
    p.req.ridx = '0;
    p.typed    = 1'b0;
    p.view     = '0;
    plan.push_back(p);
  endtask

  task automatic plan_item(bit typed, tracker_view_t view, cmd_t cmd,
                           int x, int y, int w, int h, int ridx);
    plan_row_t p;
    p.is_cfg   = 1'b0;
    p.cw       = 0;
    p.ch       = 0;
    p.crdy     = 1'b0;
    p.req.cmd  = cmd;
    p.req.x    = 16'(x);
    p.req.y    = 16'(y);
    p.req.w    = 16'(w);
    p.req.h    = 16'(h);
    p.req.ridx = 3'(ridx);
    p.typed    = typed;
    p.view     = view;
    plan.push_back(p);
  endtask

  task automatic set_surface(int w, int h, bit rdy);
    in_valid <= 1'b0;
    while (view_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SURF_WIDTH;
    cfg_wdata <= COORD_W'(w);
    @(posedge clk);
    cfg_index <= CFG_SURF_HEIGHT;
    cfg_wdata <= COORD_W'(h);
    @(posedge clk);
    cfg_index <= CFG_SURF_READY;
    cfg_wdata <= COORD_W'(rdy);
    @(posedge clk);
    cfg_we   <= 1'b0;
    surf_w   = w;
    surf_h   = h;
    surf_rdy = rdy;
  endtask

  task automatic offer(damage_req_t r, bit typed, tracker_view_t view);
    tracker_view_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= r.cmd;
    in_rect_x     <= r.x;
    in_rect_y     <= r.y;
    in_rect_w     <= r.w;
    in_rect_h     <= r.h;
    in_read_index <= r.ridx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    v = track_cmd(r);
    view_q.push_back(typed ? view : v);
  endtask

  task automatic check_field(string tag, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, tag, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  // one long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    tracker_view_t got;
    tracker_view_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_dirty_flag, out_bound_x, out_bound_y, out_bound_w, out_bound_h,
             out_rect_count, out_merge_count, out_entry_valid,
             out_entry_x, out_entry_y, out_entry_w, out_entry_h};
      if (view_q.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, got);
        errors++;
      end else begin
        want = view_q.pop_front();
        check_field("dirty_flag", want.dirty, got.dirty);
        check_field("bound_x", want.bx, got.bx);
        check_field("bound_y", want.by, got.by);
        check_field("bound_w", want.bw, got.bw);
        check_field("bound_h", want.bh, got.bh);
        check_field("rect_count", want.cnt, got.cnt);
        check_field("merge_count", want.merges, got.merges);
        check_field("entry_valid", want.ev, got.ev);
        check_field("entry_x", want.ex, got.ex);
        check_field("entry_y", want.ey, got.ey);
        check_field("entry_w", want.ew, got.ew);
        check_field("entry_h", want.eh, got.eh);
      end
    end
  end

  initial begin
    #10000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int pw;
    int ph;
    int pn;
    bit pr;

    // surface unusable after reset
    plan_item(1, VIEW_RESET, CMD_QUERY, 0, 0, 0, 0, 0);
    plan_item(1, VIEW_RESET, CMD_INV_RECT, 0, 0, 10, 10, 0);
    plan_item(1, VIEW_DIRTY_ONLY, CMD_INV_ALL, 0, 0, 0, 0, 0);
    plan_item(1, VIEW_RESET, CMD_CLEAR, 0, 0, 0, 0, 0);
    plan_cfg(32767, 32767, 1);
    plan_item(1, VIEW_FULL, CMD_INV_ALL, 0, 0, 0, 0, 0);
    plan_item(1, VIEW_FULL_BOUND, CMD_QUERY, 0, 0, 0, 0, 1);
    plan_item(1, VIEW_RESET, CMD_CLEAR, 0, 0, 0, 0, 0);
    // extreme coordinates clipped to the full surface
    plan_item(1, VIEW_FULL, CMD_INV_RECT, -32768, -32768, 65535, 65535, 0);
    plan_item(1, VIEW_RESET, CMD_CLEAR, 0, 0, 0, 0, 7);
    // empty after clipping: past far corner, zero width, wholly off-surface
    plan_item(1, VIEW_RESET, CMD_INV_RECT, 32767, 32767, 65535, 65535, 0);
    plan_item(1, VIEW_RESET, CMD_INV_RECT, 10, 10, 0, 5, 0);
    plan_item(1, VIEW_RESET, CMD_INV_RECT, -100, -100, 50, 50, 0);
    // merge on a shared edge, then appends until the list fills and collapses
    plan_item(0, VIEW_RESET, CMD_INV_RECT, 100, 100, 20, 20, 0);
    plan_item(0, VIEW_RESET, CMD_INV_RECT, 120, 100, 10, 20, 0);
    plan_item(0, VIEW_RESET, CMD_INV_RECT, 0, 0, 5, 5, 1);
    for (int k = 1; k <= 6; k++)
      plan_item(0, VIEW_RESET, CMD_INV_RECT, 1000 * k, 1000 * k, 1, 1, k + 1);
    plan_item(0, VIEW_RESET, CMD_INV_RECT, 7000, 7000, 1, 1, 0);
    plan_item(0, VIEW_RESET, CMD_QUERY, 0, 0, 0, 0, 7);
    plan_item(0, VIEW_RESET, CMD_INV_ALL, 0, 0, 0, 0, 0);
    plan_item(0, VIEW_RESET, CMD_QUERY, -1, -1, 65535, 65535, 3);

    repeat (9) @(posedge clk);
    rst_n         <= 1'b1;
    send_idle_pct = 17;
    recv_idle_pct = 52;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_surface(plan[i].cw, plan[i].ch, plan[i].crdy);
      else offer(plan[i].req, plan[i].typed, plan[i].view);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin pw = 32767; ph = 32767; pr = 1; pn = 240; end
        1: begin pw = 1; ph = 1; pr = 1; pn = 160; end
        2: begin pw = 64; ph = 48; pr = 1; pn = 280; end
        3: begin pw = $urandom_range(32767, 1); ph = $urandom_range(2000, 1); pr = 1; pn = 280; end
        4: begin pw = 32767; ph = 1; pr = 1; pn = 220; end
        5: begin pw = 200; ph = 0; pr = 1; pn = 40; end
        6: begin pw = 100; ph = 100; pr = 0; pn = 40; end
        7: begin pw = $urandom_range(300, 1); ph = $urandom_range(300, 1); pr = 1; pn = 280; end
        default: begin pw = 48; ph = 32767; pr = 1; pn = 300; end
      endcase
      set_surface(pw, ph, pr);
      if (p < 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 52;
      end else if (p < 6) begin
        send_idle_pct = 52;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 7) hold_go = 1'b1;
      for (int n = 0; n < pn; n++) offer(next_req(), 1'b0, VIEW_RESET);
    end

    in_valid <= 1'b0;
    while (view_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
